@@ design/mhrrn_pkg.sv @@
// mhrrn_pkg: shared constants and types for the multilevel HRRN scheduler.
// No dependencies.
`default_nettype none
package mhrrn_pkg;
   localparam int DEF_TABLE_SLOTS = 16;
   localparam logic [7:0] QUANTUM_RESET = 8'd10;
   localparam logic [7:0] HIGH_LIMIT_RESET = 8'd9;
   localparam logic [7:0] MID_LIMIT_RESET = 8'd19;
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_STEP = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [1:0] REG_QUANTUM = 2'd0;
   localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
   localparam logic [1:0] REG_MID_LIMIT = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [1:0]  level;
      logic [23:0] arrival;
      logic [15:0] service;
      logic [15:0] left;
   } slot_type;

   typedef struct packed {
      logic        table_full;
      logic        all_done;
      logic [31:0] turnaround;
      logic        job_finished;
      logic [31:0] time_now;
      logic [7:0]  run_length;
      logic [15:0] chosen_id;
      logic        idle_tick;
   } rsp_type;
endpackage
`default_nettype wire

@@ design/multilevel_hrrn_scheduler.sv @@
// multilevel_hrrn_scheduler: top level; job table memory, slot scan, update.
// Depends on mhrrn_pkg.
//
// channel | dir | tdata fields (low first)
// req     | in  | opcode, job_id, job_priority, job_arrival, job_service
// rsp     | out | idle_tick, chosen_id, run_length, time_now, job_finished,
//         |     | turnaround, all_done, table_full
// csr     | in  | APB, quantum / high_level_limit / mid_level_limit
//
// Load and clear go through the apply and output states. A step reads the
// table one slot a cycle, level by level, up to the first level with a ready
// job; there each new best restarts the scan behind the 40x16 cross-multiply
// compare, and the chosen slot is then fetched and updated. One item at a
// time; a result waits in the output register, and the next item is taken
// once it drains.
// Reset clears counters, clock and flags and loads CSR defaults; table needs none.
`default_nettype none
module multilevel_hrrn_scheduler
   import mhrrn_pkg::*;
#(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // opcode[1:0], job_id[17:2], job_priority[25:18], job_arrival[49:26],
   // job_service[65:50], zero fill
   input  wire logic [71:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // idle_tick[0], chosen_id[16:1], run_length[24:17], time_now[56:25],
   // job_finished[57], turnaround[89:58], all_done[90], table_full[91], zero fill
   output logic [95:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_APPLY = 3'd3;
   localparam logic [2:0] ST_OUT = 3'd4;

   logic [7:0] quantum_ff, high_ff, mid_ff;
   logic [2:0] state_ff;
   logic [CW-1:0] count_ff, done_ff;
   logic [31:0] clock_ff;
   logic [71:0] req_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   slot_type mem [TABLE_SLOTS];
   slot_type rd_ff;
   logic [SW-1:0] rd_addr;
   logic rd_en;
   logic wr_en;
   logic [SW-1:0] wr_addr;
   slot_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // scan pipeline: issue index, data valid stage, product stage
   logic [1:0] lvl_ff;
   logic [CW-1:0] idx_ff;
   logic v1_ff;
   logic [SW-1:0] s1_ff;
   logic v2_ff;
   logic [SW-1:0] s2_ff;
   logic [15:0] sv2_ff;
   logic [39:0] n2_ff;
   logic have_ff;
   logic [SW-1:0] best_ff;
   logic [15:0] bsv_ff;
   logic [39:0] bn_ff;
   logic [55:0] pa_ff, pb_ff;
   logic v3_ff;
   logic [SW-1:0] s3_ff;
   logic [15:0] sv3_ff;
   logic [39:0] n3_ff;

   // a new best flushes the items compared against the old one
   wire logic take_best = state_ff == ST_SCAN && v3_ff && pa_ff > pb_ff;
   wire logic seed = state_ff == ST_SCAN && v2_ff && !have_ff;

   logic rdy1;
   logic [39:0] n1;
   always_comb begin
      rdy1 = v1_ff && rd_ff.level == lvl_ff && rd_ff.left != 16'd0 &&
             {8'd0, rd_ff.arrival} <= clock_ff;
      n1 = {8'd0, clock_ff - {8'd0, rd_ff.arrival}} + {24'd0, rd_ff.service};
   end

   wire logic cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[3:2])
         REG_QUANTUM:    csr_prdata = {24'd0, quantum_ff};
         REG_HIGH_LIMIT: csr_prdata = {24'd0, high_ff};
         REG_MID_LIMIT:  csr_prdata = {24'd0, mid_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = state_ff == ST_IDLE && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'd0, rsp_ff};

   wire logic [1:0] op = req_ff[1:0];
   logic [7:0] qeff, run;
   always_comb begin
      qeff = (quantum_ff == 8'd0) ? 8'd1 : quantum_ff;
      run = (rd_ff.left < {8'd0, qeff}) ? rd_ff.left[7:0] : qeff;
   end

   rsp_type rsp_in;
   logic [CW-1:0] count_in, done_in;
   logic [31:0] clock_in;
   always_comb begin
      rsp_in = '0;
      count_in = count_ff;
      done_in = done_ff;
      clock_in = clock_ff;
      case (op)
         OP_LOAD: begin
            if (count_ff >= SLOTS_C) rsp_in.table_full = 1'b1;
            else begin
               count_in = count_ff + 1'b1;
               if (req_ff[65:50] == 16'd0) done_in = done_ff + 1'b1;
            end
         end
         OP_STEP: begin
            if (have_ff) begin
               clock_in = clock_ff + {24'd0, run};
               rsp_in.chosen_id = rd_ff.id;
               rsp_in.run_length = run;
               if (rd_ff.left == {8'd0, run}) begin
                  rsp_in.job_finished = 1'b1;
                  rsp_in.turnaround = clock_in - {8'd0, rd_ff.arrival};
                  done_in = done_ff + 1'b1;
               end
            end else begin
               rsp_in.idle_tick = 1'b1;
               clock_in = clock_ff + 32'd1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            done_in = '0;
            clock_in = '0;
         end
         default: ;
      endcase
      rsp_in.time_now = clock_in;
      rsp_in.all_done = done_in == count_in;
   end

   logic scan_end;
   always_comb begin
      scan_end = idx_ff >= count_ff && !v1_ff && !v2_ff && !v3_ff;
      rd_en = 1'b0;
      rd_addr = idx_ff[SW-1:0];
      if (state_ff == ST_SCAN && idx_ff < count_ff) rd_en = 1'b1;
      if (state_ff == ST_FETCH) begin
         rd_en = 1'b1;
         rd_addr = best_ff;
      end
      wr_en = 1'b0;
      wr_addr = count_ff[SW-1:0];
      wr_data.id = req_ff[17:2];
      wr_data.level = (req_ff[25:18] <= high_ff) ? 2'd0 :
                      (req_ff[25:18] <= mid_ff) ? 2'd1 : 2'd2;
      wr_data.arrival = req_ff[49:26];
      wr_data.service = req_ff[65:50];
      wr_data.left = req_ff[65:50];
      if (state_ff == ST_APPLY && op == OP_LOAD && count_ff < SLOTS_C) wr_en = 1'b1;
      if (state_ff == ST_APPLY && op == OP_STEP && have_ff) begin
         wr_en = 1'b1;
         wr_addr = best_ff;
         wr_data = rd_ff;
         wr_data.left = rd_ff.left - {8'd0, run};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
         high_ff <= HIGH_LIMIT_RESET;
         mid_ff <= MID_LIMIT_RESET;
         state_ff <= ST_IDLE;
         count_ff <= '0;
         done_ff <= '0;
         clock_ff <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            case (csr_paddr[3:2])
               REG_QUANTUM:    quantum_ff <= csr_pwdata[7:0];
               REG_HIGH_LIMIT: high_ff <= csr_pwdata[7:0];
               REG_MID_LIMIT:  mid_ff <= csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         v1_ff <= rd_en && state_ff == ST_SCAN && !take_best;
         s1_ff <= idx_ff[SW-1:0];
         v2_ff <= rdy1 && !take_best;
         s2_ff <= s1_ff;
         sv2_ff <= rd_ff.service;
         n2_ff <= n1;
         pa_ff <= {16'd0, n2_ff} * {40'd0, bsv_ff};
         pb_ff <= {16'd0, bn_ff} * {40'd0, sv2_ff};
         v3_ff <= v2_ff && have_ff && !take_best;
         s3_ff <= s2_ff;
         sv3_ff <= sv2_ff;
         n3_ff <= n2_ff;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  req_ff <= req_tdata;
                  lvl_ff <= 2'd0;
                  idx_ff <= '0;
                  have_ff <= 1'b0;
                  state_ff <= (req_tdata[1:0] == OP_STEP) ? ST_SCAN : ST_APPLY;
               end
            end
            ST_SCAN: begin
               if (take_best) begin
                  best_ff <= s3_ff;
                  bsv_ff <= sv3_ff;
                  bn_ff <= n3_ff;
                  idx_ff <= CW'(s3_ff) + 1'b1;
               end else begin
                  // first ready job of the level seeds the best; later ones compare
                  if (seed) begin
                     have_ff <= 1'b1;
                     best_ff <= s2_ff;
                     bsv_ff <= sv2_ff;
                     bn_ff <= n2_ff;
                  end
                  if (scan_end) begin
                     if (have_ff) state_ff <= ST_FETCH;
                     else if (lvl_ff == 2'd2) state_ff <= ST_APPLY;
                     else begin
                        lvl_ff <= lvl_ff + 2'd1;
                        idx_ff <= '0;
                     end
                  end else if (rd_en) idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_FETCH: state_ff <= ST_APPLY;
            ST_APPLY: begin
               rsp_ff <= rsp_in;
               count_ff <= count_in;
               done_ff <= done_in;
               clock_ff <= clock_in;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_C && done_ff <= count_ff) else $error("count range");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE && !rsp_valid_ff) else $error("ready busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("rsp changed");
`endif
endmodule
`default_nettype wire
